>>> src/cts_pkg.sv
// Shared constants, types and register codes for the cosine top-k search.
// No dependencies.
package cts_pkg;

  localparam int MAX_VECTORS = 1024;
  localparam int VIDX_W      = $clog2(MAX_VECTORS);
  localparam int VCNT_W      = VIDX_W + 1;
  localparam int MAX_DIM     = 256;
  localparam int EIDX_W      = $clog2(MAX_DIM);
  localparam int DCNT_W      = EIDX_W + 1;
  localparam int MAX_TOPN    = 63;
  localparam int NCELLS      = MAX_TOPN + 1;
  localparam int RANK_W      = 6;
  localparam int ADDR_W      = VIDX_W + EIDX_W;

  localparam int ELEM_W   = 16;
  localparam int PROD_W   = 2 * ELEM_W;
  localparam int ACC_W    = 40;
  localparam int MAG_W    = ACC_W - 1;
  localparam int SQ_IN_W  = 48;
  localparam int NORM_W   = SQ_IN_W / 2;
  localparam int DEN_W    = 2 * NORM_W;
  localparam int SIM_W    = 16;
  localparam int QBITS    = 17;
  localparam int SIM_ONE  = 16384;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_VECTOR_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_IN_USE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_COUNT    = 2'd2;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic                    valid;
    logic signed [SIM_W-1:0] sim;
    logic [VIDX_W-1:0]       idx;
  } entry_t;

endpackage

>>> src/cts_if.sv
// Channel interfaces: query/load input and ranked result output.
// Depends on cts_pkg.
interface cts_in_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic [cts_pkg::VIDX_W-1:0]          vector_index;
  logic [cts_pkg::EIDX_W-1:0]          element_index;
  logic signed [cts_pkg::ELEM_W-1:0]   element_value;
  modport source (output valid, kind, vector_index, element_index, element_value,
                  input ready);
  modport sink   (input valid, kind, vector_index, element_index, element_value,
                  output ready);
endinterface

interface cts_out_if;
  logic                               valid;
  logic                               ready;
  logic [cts_pkg::RANK_W-1:0]         rank;
  logic [cts_pkg::VIDX_W-1:0]         match_index;
  logic signed [cts_pkg::SIM_W-1:0]   similarity;
  logic                               last;
  modport source (output valid, rank, match_index, similarity, last, input ready);
  modport sink   (input valid, rank, match_index, similarity, last, output ready);
endinterface

>>> src/cts_sqrt.sv
// Iterative integer square root, one result bit per cycle.
// Depends on cts_pkg.
module cts_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [cts_pkg::SQ_IN_W-1:0]   x,
  output logic                          done,
  output logic [cts_pkg::NORM_W-1:0]    root
);
  import cts_pkg::*;

  localparam int CNT_W = $clog2(NORM_W);

  logic [SQ_IN_W-1:0] xs;
  logic [NORM_W+2:0]  rem;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic [NORM_W+2:0]  trial;
  logic [NORM_W+2:0]  sub;
  logic               take;

  assign trial = {rem[NORM_W:0], xs[SQ_IN_W-1 -: 2]};
  assign sub   = {1'b0, root, 2'b01};
  assign take  = trial >= sub;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        xs   <= x;
        rem  <= '0;
        root <= '0;
        cnt  <= CNT_W'(NORM_W - 1);
        busy <= 1'b1;
      end else if (busy) begin
        xs   <= {xs[SQ_IN_W-3:0], 2'b00};
        rem  <= take ? trial - sub : trial;
        root <= {root[NORM_W-2:0], take};
        cnt  <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> src/cts_div.sv
// Restoring divider for the similarity quotient, rounded, saturated, signed.
// Depends on cts_pkg.
module cts_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [cts_pkg::MAG_W-1:0]         mag,
  input  logic                              neg,
  input  logic [cts_pkg::DEN_W-1:0]         den,
  output logic                              done,
  output logic signed [cts_pkg::SIM_W-1:0]  sim
);
  import cts_pkg::*;

  localparam int NUM_W = MAG_W + 22;
  localparam int DSH_W = DEN_W + QBITS - 1;
  localparam int CNT_W = $clog2(QBITS);

  logic [NUM_W-1:0] rem;
  logic [DSH_W-1:0] dsh;
  logic [QBITS-1:0] q;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             zero;
  logic             sgn;
  logic             take;
  logic [QBITS-1:0] q_fin;
  logic [QBITS-1:0] q_sat;

  assign take  = {{(DSH_W-NUM_W){1'b0}}, rem} >= dsh;
  assign q_fin = {q[QBITS-2:0], take};
  assign q_sat = (q_fin > QBITS'(SIM_ONE)) ? QBITS'(SIM_ONE) : q_fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= {mag, 22'd0} + NUM_W'(den[DEN_W-1:1]);
        dsh  <= {den, {(QBITS-1){1'b0}}};
        q    <= '0;
        cnt  <= CNT_W'(QBITS - 1);
        zero <= (den == '0);
        sgn  <= neg;
        busy <= 1'b1;
      end else if (busy) begin
        if (take) rem <= rem - dsh[NUM_W-1:0];
        dsh <= dsh >> 1;
        q   <= q_fin;
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
          if (zero) sim <= '0;
          else if (sgn) sim <= -$signed(SIM_W'(q_sat));
          else sim <= $signed(SIM_W'(q_sat));
        end
      end
    end
  end
endmodule

>>> src/cts_cell.sv
// One cell of the ranking chain: keeps the better entry, passes the other on.
// Depends on cts_pkg.
module cts_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            clear,
  input  logic            shift,
  input  cts_pkg::entry_t cand_in,
  input  cts_pkg::entry_t up_in,
  output cts_pkg::entry_t held,
  output cts_pkg::entry_t cand_out
);
  import cts_pkg::*;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      held.valid     <= 1'b0;
      cand_out.valid <= 1'b0;
    end else if (shift) begin
      held           <= up_in;
      cand_out.valid <= 1'b0;
    end else begin
      cand_out.valid <= 1'b0;
      if (cand_in.valid) begin
        if (!held.valid) begin
          held <= cand_in;
        end else if (($signed(cand_in.sim) > $signed(held.sim)) ||
                     (cand_in.sim == held.sim && cand_in.idx < held.idx)) begin
          held     <= cand_in;
          cand_out <= held;
        end else begin
          cand_out <= cand_in;
        end
      end
    end
  end
endmodule

>>> src/cosine_topk_search.sv
// channel | dir | transfer carries
// in_ch   | in  | kind, vector_index, element_index, element_value
// out_ch  | out | rank, match_index, similarity, last
// wr_*    | in  | register write, no handshake
// A load writes its element to the table on transfer. A query with stale norms
// computes the norms first; then come a check step, the cosines (N vectors, D
// elements, one element read a cycle from the table), the ranking chain drain
// and one result per cycle while out_ch is ready. Synchronous reset; loads and
// queries are refused while a query runs or its results stall.
// Depends on cts_pkg, cts_if, cts_sqrt, cts_div, cts_cell.
module cosine_topk_search (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [cts_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [cts_pkg::CFG_DATA_W-1:0]   wr_data,
  cts_in_if.sink                           in_ch,
  cts_out_if.source                        out_ch
);
  import cts_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE      = 10'b0000000001,
    S_NORM_RD   = 10'b0000000010,
    S_NORM_WAIT = 10'b0000000100,
    S_NORM_SQ   = 10'b0000001000,
    S_CHECK     = 10'b0000010000,
    S_DOT_RD    = 10'b0000100000,
    S_DOT_WAIT  = 10'b0001000000,
    S_DOT_DIV   = 10'b0010000000,
    S_DRAIN     = 10'b0100000000,
    S_EMIT      = 10'b1000000000
  } state_t;

  state_t state, state_next;

  logic [VCNT_W-1:0] vcount;
  logic [DCNT_W-1:0] dim;
  logic [RANK_W-1:0] topc;
  logic              norms_valid;

  logic [VCNT_W-1:0] nv;
  logic [DCNT_W-1:0] dimu;
  logic [RANK_W:0]   runlen;

  logic [VIDX_W-1:0] qidx;
  logic [VIDX_W-1:0] vcur;
  logic [EIDX_W-1:0] ecnt;
  logic [RANK_W-1:0] dcnt;
  logic [RANK_W-1:0] rank;

  logic              last_vec;
  logic              last_elem;
  logic              in_xfer;
  logic              out_xfer;

  logic signed [ELEM_W-1:0] vmem [MAX_VECTORS*MAX_DIM];
  logic [NORM_W-1:0]        nmem [MAX_VECTORS];

  logic [ADDR_W-1:0] addr_a, addr_b;
  logic              iss_valid, iss_first, iss_last;
  logic signed [ELEM_W-1:0] rd_a, rd_b;
  logic              p1_valid, p1_first, p1_last;
  logic signed [PROD_W-1:0] prod;
  logic              p2_valid, p2_first, p2_last;
  logic signed [ACC_W-1:0]  acc;
  logic              acc_done;
  logic [ACC_W-1:0]  acc_abs;

  logic [NORM_W-1:0] nq_rd, nv_rd;
  logic [DEN_W-1:0]  den;

  logic              sq_start, sq_done;
  logic [NORM_W-1:0] sq_root;
  logic              dv_start, dv_done;
  logic signed [SIM_W-1:0] dv_sim;

  entry_t inj;
  entry_t held [NCELLS];
  entry_t cand [NCELLS+1];
  logic   chain_clear;
  logic   chain_shift;

  assign nv = (vcount == '0) ? VCNT_W'(1) :
              (vcount > VCNT_W'(MAX_VECTORS)) ? VCNT_W'(MAX_VECTORS) : vcount;
  assign dimu = (dim == '0) ? DCNT_W'(1) :
                (dim > DCNT_W'(MAX_DIM)) ? DCNT_W'(MAX_DIM) : dim;
  assign runlen = ((VCNT_W'(topc) + 1'b1) > nv) ? (RANK_W+1)'(nv)
                                                 : ({1'b0, topc} + 1'b1);

  assign last_vec  = ({1'b0, vcur} == nv - 1'b1);
  assign last_elem = ({1'b0, ecnt} == dimu - 1'b1);
  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign out_xfer  = out_ch.valid && out_ch.ready;

  assign in_ch.ready = (state == S_IDLE);

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      vcount      <= VCNT_W'(MAX_VECTORS);
      dim         <= DCNT_W'(MAX_DIM);
      topc        <= RANK_W'(10);
      norms_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_VECTOR_COUNT: begin
            vcount      <= wr_data[VCNT_W-1:0];
            norms_valid <= 1'b0;
          end
          REG_DIM_IN_USE: begin
            dim         <= wr_data[DCNT_W-1:0];
            norms_valid <= 1'b0;
          end
          REG_TOP_COUNT: topc <= wr_data[RANK_W-1:0];
          default: ;
        endcase
      end
      if (in_xfer && in_ch.kind == KIND_LOAD) norms_valid <= 1'b0;
      if (state == S_NORM_SQ && sq_done && last_vec) norms_valid <= 1'b1;
    end
  end

  // element table and norm table
  always_comb begin
    addr_a    = {vcur, ecnt};
    addr_b    = {vcur, ecnt};
    iss_valid = 1'b0;
    if (state == S_DOT_RD) addr_a = {qidx, ecnt};
    if (state == S_NORM_RD || state == S_DOT_RD) iss_valid = 1'b1;
    iss_first = (ecnt == '0);
    iss_last  = last_elem;
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_ch.kind == KIND_LOAD)
      vmem[{in_ch.vector_index, in_ch.element_index}] <= in_ch.element_value;
    rd_a <= vmem[addr_a];
    rd_b <= vmem[addr_b];
    if (state == S_NORM_SQ && sq_done) nmem[vcur] <= sq_root;
    nq_rd <= nmem[qidx];
    nv_rd <= nmem[vcur];
    den   <= nq_rd * nv_rd;
  end

  // multiply-accumulate pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      acc_done <= 1'b0;
    end else begin
      p1_valid <= iss_valid;
      p1_first <= iss_first;
      p1_last  <= iss_last;
      p2_valid <= p1_valid;
      p2_first <= p1_first;
      p2_last  <= p1_last;
      prod     <= rd_a * rd_b;
      if (p2_valid) acc <= p2_first ? ACC_W'(prod) : acc + ACC_W'(prod);
      acc_done <= p2_valid && p2_last;
    end
  end

  assign acc_abs  = acc[ACC_W-1] ? -acc : acc;
  assign sq_start = (state == S_NORM_WAIT) && acc_done;
  assign dv_start = (state == S_DOT_WAIT) && acc_done;

  cts_sqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .start(sq_start),
    .x    ({1'b0, acc[MAG_W-1:0], 8'd0}),
    .done (sq_done),
    .root (sq_root)
  );

  cts_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(dv_start),
    .mag  (acc_abs[MAG_W-1:0]),
    .neg  (acc[ACC_W-1]),
    .den  (den),
    .done (dv_done),
    .sim  (dv_sim)
  );

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:
        if (in_xfer && in_ch.kind == KIND_QUERY)
          state_next = norms_valid ? S_CHECK : S_NORM_RD;
      S_NORM_RD:   if (last_elem) state_next = S_NORM_WAIT;
      S_NORM_WAIT: if (acc_done) state_next = S_NORM_SQ;
      S_NORM_SQ:   if (sq_done) state_next = last_vec ? S_CHECK : S_NORM_RD;
      S_CHECK:     state_next = ({1'b0, qidx} >= nv) ? S_IDLE : S_DOT_RD;
      S_DOT_RD:    if (last_elem) state_next = S_DOT_WAIT;
      S_DOT_WAIT:  if (acc_done) state_next = S_DOT_DIV;
      S_DOT_DIV:   if (dv_done) state_next = last_vec ? S_DRAIN : S_DOT_RD;
      S_DRAIN:     if (dcnt == RANK_W'(NCELLS - 1)) state_next = S_EMIT;
      S_EMIT:      if (out_xfer && out_ch.last) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      inj.valid <= 1'b0;
    end else begin
      state     <= state_next;
      inj.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          qidx <= in_ch.vector_index;
          vcur <= '0;
          ecnt <= '0;
        end
        S_NORM_RD, S_DOT_RD:
          ecnt <= last_elem ? '0 : ecnt + 1'b1;
        S_NORM_SQ:
          if (sq_done) vcur <= last_vec ? '0 : vcur + 1'b1;
        S_DOT_DIV:
          if (dv_done) begin
            inj.valid <= 1'b1;
            inj.sim   <= dv_sim;
            inj.idx   <= vcur;
            vcur      <= vcur + 1'b1;
            dcnt      <= '0;
          end
        S_DRAIN: begin
          dcnt <= dcnt + 1'b1;
          rank <= '0;
        end
        S_EMIT:
          if (out_xfer) rank <= rank + 1'b1;
        default: ;
      endcase
    end
  end

  // ranking chain
  assign chain_clear = (state == S_CHECK);
  assign chain_shift = out_xfer;
  assign cand[0]     = inj;

  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    entry_t up;
    if (i == NCELLS - 1) begin : g_end
      assign up = '0;
    end else begin : g_mid
      assign up = held[i+1];
    end
    cts_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .clear   (chain_clear),
      .shift   (chain_shift),
      .cand_in (cand[i]),
      .up_in   (up),
      .held    (held[i]),
      .cand_out(cand[i+1])
    );
  end

  assign out_ch.valid       = (state == S_EMIT);
  assign out_ch.rank        = rank;
  assign out_ch.match_index = held[0].idx;
  assign out_ch.similarity  = held[0].sim;
  assign out_ch.last        = ({1'b0, rank} + 1'b1 == runlen);
endmodule

>>> src/cts_checker.sv
// Port-level checks on the cosine top-k search, bound to the top level.
// Depends on cosine_topk_search ports only.
module cts_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic in_kind,
  input logic out_valid,
  input logic out_ready,
  input logic [5:0] out_rank,
  input logic out_last
);
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input open while results pending");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !out_last) |=>
      (out_valid && out_rank == $past(out_rank) + 6'd1))
    else $error("result run broken");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_last) |=> in_ready)
    else $error("block not idle after final result");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_kind) |=> !in_ready)
    else $error("query did not start");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_rank)))
    else $error("stalled result changed");
endmodule

bind cosine_topk_search cts_checker u_cts_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_ch.valid),
  .in_ready (in_ch.ready),
  .in_kind  (in_ch.kind),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_rank (out_ch.rank),
  .out_last (out_ch.last)
);

>>> tb/tb_top.sv
// Self-checking testbench for cosine_topk_search: loads and queries go in over
// cts_in_if, ranked matches are compared against an in-bench ranking predictor.
// Depends on cts_pkg, cts_if and cosine_topk_search.
module tb_top;
  import cts_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int WDOG_LIMIT = 400000;

  typedef struct {
    logic [RANK_W-1:0]       rank;
    logic [VIDX_W-1:0]       idx;
    logic signed [SIM_W-1:0] sim;
    logic                    last;
  } match_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] wr_index = '0;
  logic [CFG_DATA_W-1:0] wr_data = '0;

  cts_in_if  in_ch ();
  cts_out_if out_ch ();

  cosine_topk_search DUT (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always #2 clk = ~clk;

  // predictor state
  logic signed [ELEM_W-1:0] table_mem [0:MAX_VECTORS*MAX_DIM-1];
  bit                       written   [0:MAX_VECTORS*MAX_DIM-1];
  logic [31:0]              norm_mem  [0:MAX_VECTORS-1];
  bit                       norms_ok;
  logic [10:0]              vc_reg;
  logic [8:0]               dim_reg;
  logic [5:0]               top_reg;
  match_t                   match_q [$];

  int errors, n_loads, n_queries, n_results, wdog;
  bit calm;
  int sink_stall;

  function automatic int used_vc();
    return (vc_reg < 1) ? 1 : (vc_reg > MAX_VECTORS) ? MAX_VECTORS : int'(vc_reg);
  endfunction

  function automatic int used_dim();
    return (dim_reg < 1) ? 1 : (dim_reg > MAX_DIM) ? MAX_DIM : int'(dim_reg);
  endfunction

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [SIM_W-1:0] cosine_q14(int q, int v, int d);
    longint dot;
    longint unsigned den, mag, r;
    dot = 0;
    for (int e = 0; e < d; e++)
      dot += longint'(table_mem[q*MAX_DIM+e]) * longint'(table_mem[v*MAX_DIM+e]);
    den = longint'(norm_mem[q]) * longint'(norm_mem[v]);
    if (den == 0) return '0;
    mag = (dot < 0) ? -dot : dot;
    r = ((mag << 22) + den / 2) / den;
    if (r > SIM_ONE) r = SIM_ONE;
    return (dot < 0) ? -SIM_W'(r) : SIM_W'(r);
  endfunction

  task automatic predict_ranking(logic [VIDX_W-1:0] qi);
    int nv, d, runlen, best;
    longint unsigned acc;
    logic signed [SIM_W-1:0] sims [0:MAX_VECTORS-1];
    bit used [0:MAX_VECTORS-1];
    match_t m;
    nv = used_vc();
    d = used_dim();
    if (!norms_ok) begin
      for (int v = 0; v < nv; v++) begin
        acc = 0;
        for (int e = 0; e < d; e++)
          acc += longint'(table_mem[v*MAX_DIM+e]) * longint'(table_mem[v*MAX_DIM+e]);
        norm_mem[v] = 32'(root64(acc << 8));
      end
      norms_ok = 1;
    end
    if (qi >= nv) return;
    for (int v = 0; v < nv; v++) begin
      sims[v] = cosine_q14(qi, v, d);
      used[v] = 0;
    end
    runlen = ((top_reg > MAX_TOPN) ? MAX_TOPN : top_reg) + 1;
    if (runlen > nv) runlen = nv;
    for (int k = 0; k < runlen; k++) begin
      best = -1;
      for (int v = 0; v < nv; v++)
        if (!used[v] && (best < 0 || sims[v] > sims[best])) best = v;
      used[best] = 1;
      m.rank = RANK_W'(k);
      m.idx = VIDX_W'(best);
      m.sim = sims[best];
      m.last = (k + 1 == runlen);
      match_q.push_back(m);
    end
  endtask

  task automatic report(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
  endtask

  // input side
  task automatic send_item(logic kind, logic [VIDX_W-1:0] vi, logic [EIDX_W-1:0] ei,
                           logic signed [ELEM_W-1:0] val);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.kind = kind;
    in_ch.vector_index = vi;
    in_ch.element_index = ei;
    in_ch.element_value = val;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    if (kind == KIND_LOAD) begin
      n_loads++;
      table_mem[vi*MAX_DIM+ei] = val;
      written[vi*MAX_DIM+ei] = 1;
      norms_ok = 0;
    end else begin
      n_queries++;
      predict_ranking(vi);
    end
  endtask

  task automatic load_elem(int v, int e, logic signed [ELEM_W-1:0] val);
    send_item(KIND_LOAD, VIDX_W'(v), EIDX_W'(e), val);
  endtask

  task automatic query(int v);
    send_item(KIND_QUERY, VIDX_W'(v), EIDX_W'($urandom), ELEM_W'($urandom));
  endtask

  function automatic logic signed [ELEM_W-1:0] rand_elem();
    case ($urandom_range(0, 3))
      0: return ELEM_W'($urandom);
      1: return ELEM_W'($signed($urandom_range(0, 4)) - 2) <<< 12;
      2: return '0;
      default: return ELEM_W'($signed($urandom_range(0, 512)) - 256);
    endcase
  endfunction

  // hold off until every match has arrived and the block has gone idle
  task automatic settle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (match_q.size() != 0 || !in_ch.ready) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(negedge clk);
    wr_en = 1'b1;
    wr_index = idx;
    wr_data = CFG_DATA_W'(val);
    @(negedge clk);
    wr_en = 1'b0;
    case (idx)
      REG_VECTOR_COUNT: begin vc_reg = 11'(val); norms_ok = 0; end
      REG_DIM_IN_USE:   begin dim_reg = 9'(val); norms_ok = 0; end
      REG_TOP_COUNT:    top_reg = 6'(val);
      default: ;
    endcase
  endtask

  task automatic setup(int vc, int d, int top);
    settle();
    write_reg(REG_VECTOR_COUNT, vc);
    write_reg(REG_DIM_IN_USE, d);
    write_reg(REG_TOP_COUNT, top);
  endtask

  // every element a query can read gets written first
  task automatic fill_table();
    for (int v = 0; v < used_vc(); v++)
      for (int e = 0; e < used_dim(); e++)
        if (!written[v*MAX_DIM+e]) load_elem(v, e, rand_elem());
  endtask

  // output side
  always @(negedge clk) begin
    if (sink_stall > 0) begin
      out_ch.ready = 1'b0;
      sink_stall--;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    match_t m;
    if (!rst && out_ch.valid && out_ch.ready) begin
      n_results++;
      sink_stall = calm ? 0 : $urandom_range(0, 7);
      if (match_q.size() == 0) begin
        report("unexpected transfer", out_ch.match_index, -1);
      end else begin
        m = match_q.pop_front();
        if (out_ch.rank !== m.rank) report("rank", out_ch.rank, m.rank);
        if (out_ch.match_index !== m.idx) report("match_index", out_ch.match_index, m.idx);
        if (out_ch.similarity !== m.sim) report("similarity", out_ch.similarity, m.sim);
        if (out_ch.last !== m.last) report("last", out_ch.last, m.last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) wdog = 0;
    else wdog++;
    if (wdog >= WDOG_LIMIT) begin
      $display("watchdog expired at %0t", $time);
      $display("FAIL cosine_topk_search");
      $finish;
    end
  end

  task automatic test_directed();
    setup(4, 3, 63);
    calm = 1;
    load_elem(0, 0, 16'sh7FFF); load_elem(0, 1, '0); load_elem(0, 2, '0);
    load_elem(1, 0, 16'sh8000); load_elem(1, 1, '0); load_elem(1, 2, '0);
    load_elem(2, 0, '0);        load_elem(2, 1, '0); load_elem(2, 2, '0);
    load_elem(3, 0, 16'sh7FFF); load_elem(3, 1, 16'sh1000); load_elem(3, 2, 16'shF000);
    load_elem(1023, 255, 16'sh5555);
    calm = 0;
    query(0);
    query(2);
    query(1023);
    load_elem(3, 1, '0); load_elem(3, 2, '0);
    query(3);
    query(3);
    settle();
    write_reg(REG_TOP_COUNT, 0);
    query(1);
    settle();
    write_reg(REG_SPARE, 11'h7FF);
    query(0);
  endtask

  task automatic test_extremes();
    setup(1, 511, 5);
    fill_table();
    query(0);
    query(1);
    setup(0, 1, 63);
    query(0);
  endtask

  task automatic test_random_phase();
    int nv;
    setup($urandom_range(2, 12), $urandom_range(1, 6), $urandom_range(0, 63));
    calm = ($urandom_range(0, 3) == 0);
    fill_table();
    nv = used_vc();
    for (int i = 0; i < 30; i++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: query($urandom_range(0, nv - 1));
        11: query($urandom_range(nv, 1023));
        12, 13, 14, 15, 16, 17:
          load_elem($urandom_range(0, nv - 1), $urandom_range(0, used_dim() - 1), rand_elem());
        default: load_elem($urandom_range(0, 1023), $urandom_range(0, 255), rand_elem());
      endcase
      if (i == 15) begin
        settle();
        write_reg(REG_TOP_COUNT, $urandom_range(0, 63));
      end
    end
    calm = 0;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_LOAD;
    in_ch.vector_index = '0;
    in_ch.element_index = '0;
    in_ch.element_value = '0;
    out_ch.ready = 1'b1;
    sink_stall = 0;
    calm = 0;
    errors = 0; n_loads = 0; n_queries = 0; n_results = 0; wdog = 0;
    vc_reg = 11'd1024; dim_reg = 9'd256; top_reg = 6'd10; norms_ok = 0;
    for (int i = 0; i < MAX_VECTORS * MAX_DIM; i++) begin
      table_mem[i] = '0;
      written[i] = 0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_extremes();
    for (int p = 0; p < 3; p++) test_random_phase();
    settle();
    if (match_q.size() != 0) report("matches still owed", match_q.size(), 0);

    $display("covered %0d loads and %0d queries, %0d ranked matches checked",
             n_loads, n_queries, n_results);
    $display("register extremes, ties, zero norms, out-of-range queries and stalls exercised");
    if (errors == 0) begin
      $display("PASS cosine_topk_search");
    end else begin
      $display("FAIL cosine_topk_search");
    end
    $finish;
  end
endmodule

>>> sim.f
src/cts_pkg.sv
src/cts_if.sv
src/cts_sqrt.sv
src/cts_div.sv
src/cts_cell.sv
src/cosine_topk_search.sv
src/cts_checker.sv
tb/tb_top.sv
